// ===== rtl/rtmp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtmp_pkg: shared types and constants
// Window size, derived widths, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rtmp_pkg;

	localparam int WINDOW_DEPTH = 6;
	localparam int SAMPLE_W     = 8;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	// sum of a full window of signed samples
	localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int MAG_W        = SUM_W;
	localparam int BIT_W        = $clog2(MAG_W);
	localparam int MIN_FILL     = 2;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = -8'sd70;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_TRIM,
		ST_DIV,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic store;
		logic scan;
		logic trim;
		logic div;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic scan_last;
		logic div_done;
		logic emit;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/rtmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtmp_ctrl: sequencing FSM
// Steps one sample through store and check and, when a decision is due, window scan, trim, divide and decision.
// ----------------------------------------------------------------------------
module rtmp_ctrl import rtmp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nxt = status.go ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_nxt = ST_TRIM;
				end
			end
			ST_TRIM: begin
				cmd.trim  = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (status.div_done) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!status.emit) begin
					state_nxt = ST_IDLE;
				end else if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/rtmp_datapath.sv =====
// ----------------------------------------------------------------------------
// rtmp_datapath: window, scan accumulator, divider and output register
// Holds config, the sample window, min/max/sum scan, a restoring divider
// (one quotient bit per cycle) and the result register.
// ----------------------------------------------------------------------------
module rtmp_datapath import rtmp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [SAMPLE_W-1:0]  sample_rssi,
	input  cmd_t                        cmd,
	output status_t                     status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        unlock,
	output logic signed [SAMPLE_W-1:0]  average_rssi
);

	localparam int EXT_W = SUM_W - SAMPLE_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_DEPTH);
	localparam logic [BIT_W-1:0] DIV_LAST  = BIT_W'(MAG_W - 1);

	logic signed [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]           fill_q;
	logic [IDX_W-1:0]           slot_q;
	logic                       en_q;
	logic signed [SAMPLE_W-1:0] thr_q;
	logic [IDX_W-1:0]           idx_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           quo_q;
	logic [CNT_W-1:0]           rem_q;
	logic [BIT_W-1:0]           bit_q;
	logic                       last_q;
	logic                       out_valid_q;
	logic                       unlock_q;
	logic signed [SAMPLE_W-1:0] avg_q;

	logic signed [SAMPLE_W-1:0] s;
	logic [SUM_W-1:0]           s_ext;
	logic [SUM_W-1:0]           max_ext;
	logic [SUM_W-1:0]           min_ext;
	logic                       all_eq;
	logic [SUM_W-1:0]           trimmed;
	logic [CNT_W:0]             sh;
	logic [CNT_W+1:0]           diff;
	logic [MAG_W-1:0]           qs;
	logic signed [SAMPLE_W-1:0] avg;
	logic                       dec;

	assign s       = win_q[idx_q];
	assign s_ext   = {{EXT_W{s[SAMPLE_W-1]}}, s};
	assign max_ext = {{EXT_W{max_q[SAMPLE_W-1]}}, max_q};
	assign min_ext = {{EXT_W{min_q[SAMPLE_W-1]}}, min_q};
	assign all_eq  = (max_q == min_q);
	// all equal: drop one copy only
	assign trimmed = all_eq ? (sum_q - max_ext) : (sum_q - max_ext - min_ext);

	assign sh   = {rem_q, quo_q[MAG_W-1]};
	assign diff = {1'b0, sh} - {2'b00, cnt_q};

	// quotient magnitude back to signed; truncation toward zero
	assign qs  = neg_q ? (~quo_q + MAG_W'(1)) : quo_q;
	assign avg = qs[SAMPLE_W-1:0];
	assign dec = (avg > thr_q);

	assign status.go        = en_q && (fill_q > CNT_W'(MIN_FILL));
	assign status.scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == fill_q;
	assign status.div_done  = (bit_q == DIV_LAST);
	assign status.emit      = (dec != last_q);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign unlock       = unlock_q;
	assign average_rssi = avg_q;

	// sample window, no reset
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			win_q[slot_q] <= sample_rssi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			slot_q      <= '0;
			en_q        <= 1'b0;
			thr_q       <= THRESHOLD_RESET;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			bit_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE:    en_q  <= cfg_data[0];
					CFG_THRESHOLD: thr_q <= cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.store) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + IDX_W'(1);
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.trim) begin
				bit_q <= '0;
			end else if (cmd.div) begin
				bit_q <= bit_q + BIT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				last_q      <= dec;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (idx_q == '0) begin
				max_q <= s;
				min_q <= s;
				sum_q <= s_ext;
			end else begin
				if (s > max_q) max_q <= s;
				if (s < min_q) min_q <= s;
				sum_q <= sum_q + s_ext;
			end
		end
		if (cmd.trim) begin
			cnt_q <= all_eq ? (fill_q - CNT_W'(1)) : (fill_q - CNT_W'(2));
			neg_q <= trimmed[SUM_W-1];
			quo_q <= trimmed[SUM_W-1] ? (~trimmed + SUM_W'(1)) : trimmed;
			rem_q <= '0;
		end else if (cmd.div) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[CNT_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			unlock_q <= dec;
			avg_q    <= avg;
		end
	end

endmodule

// ===== rtl/rssi_trimmed_mean_presence.sv =====
// ----------------------------------------------------------------------------
// rssi_trimmed_mean_presence: trimmed-mean presence detector
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in       | in_valid / in_ready  | sample_rssi
//   out      | out_valid / out_ready| unlock, average_rssi
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// One word at a time: a sample is stored, then checked; when a decision
// is made the scan steps through each stored sample (up to 6), then the
// trim step, the divider (one quotient bit per cycle) and the decide step
// follow. A pending result waits in the output register;
// the next decision stalls only if that register is still full.
// Reset clears control, fill count, config and last decision; the window
// itself is not cleared.
// ----------------------------------------------------------------------------
module rssi_trimmed_mean_presence import rtmp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SAMPLE_W-1:0]  sample_rssi,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        unlock,
	output logic signed [SAMPLE_W-1:0]  average_rssi
);

	cmd_t    cmd;
	status_t status;

	rtmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rtmp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_rssi  (sample_rssi),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unlock       (unlock),
		.average_rssi (average_rssi)
	);

endmodule

// ===== rtl/rtmp_checker.sv =====
// ----------------------------------------------------------------------------
// rtmp_checker: port-level checks
// Tracks config writes and delivered decisions from the ports alone.
// ----------------------------------------------------------------------------
module rtmp_checker import rtmp_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic [CFG_IDX_W-1:0]        cfg_index,
	input logic [CFG_DATA_W-1:0]       cfg_data,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        unlock,
	input logic signed [SAMPLE_W-1:0]  average_rssi
);

	logic                       en_q;
	logic signed [SAMPLE_W-1:0] thr_q;
	logic                       prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			thr_q  <= THRESHOLD_RESET;
			prev_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_ENABLE) en_q <= cfg_data[0];
			if (cfg_we && cfg_index == CFG_THRESHOLD) thr_q <= cfg_data[SAMPLE_W-1:0];
			if (out_valid && out_ready) prev_q <= unlock;
		end
	end

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unlock) && $stable(average_rssi))
		else $error("output word changed while stalled");

	// decisions only ever toggle
	a_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unlock != prev_q)
		else $error("repeated decision delivered");

	a_unlock_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unlock |-> average_rssi > thr_q)
		else $error("unlock with average not above threshold");

	a_lock_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unlock |-> average_rssi <= thr_q)
		else $error("lock with average above threshold");

	a_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> en_q)
		else $error("decision delivered while disabled");

endmodule

bind rssi_trimmed_mean_presence rtmp_checker u_chk (.*);

// ===== tb/rssi_trimmed_mean_presence_test.sv =====
// ----------------------------------------------------------------------------
// rssi_trimmed_mean_presence_test: self-checking bench for the presence detector
// Tracks the sample window, trimmed mean and last decision of the block. Each
// accepted sample queues the decision change that it causes. Every result word
// is checked against the oldest queued change. Directed cases run first, then
// random bursts that swing above and below changing thresholds.
// ----------------------------------------------------------------------------
module rssi_trimmed_mean_presence_test;
	import rtmp_pkg::*;

	localparam int SETTLE_CYCLES  = 30;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int PHASE_ITEMS    = 40;
	localparam int RANDOM_ITEMS   = 730;

	typedef struct {
		logic                       unlock;
		logic signed [SAMPLE_W-1:0] average;
	} decision_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_rssi;
	logic                       out_valid;
	logic                       out_ready;
	logic                       unlock;
	logic signed [SAMPLE_W-1:0] average_rssi;

	// tracked block state
	logic signed [SAMPLE_W-1:0] win [WINDOW_DEPTH];
	int                         fill;
	int                         slot;
	logic                       unlocked_now;
	logic                       en_model;
	logic signed [SAMPLE_W-1:0] thr_model;

	decision_t pending_decisions[$];
	decision_t want;
	int        err_count;
	int        quiet_cycles;
	int        ready_hold;
	bit        idle_en;

	rssi_trimmed_mean_presence dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_rssi  (sample_rssi),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unlock       (unlock),
		.average_rssi (average_rssi)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string what, input int got, input int exp_val);
		$display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
		err_count++;
	endtask

	// window update plus trimmed mean; queues a word only when the decision flips
	task automatic track_sample(input logic signed [SAMPLE_W-1:0] s);
		int        total;
		int        hi;
		int        lo;
		int        n;
		int        mean;
		logic      dec;
		decision_t d;
		win[slot] = s;
		slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
		if (fill < WINDOW_DEPTH)
			fill++;
		if (en_model && fill > MIN_FILL) begin
			hi = win[0];
			lo = win[0];
			total = 0;
			for (int i = 0; i < fill; i++) begin
				total += win[i];
				if (win[i] > hi)
					hi = win[i];
				if (win[i] < lo)
					lo = win[i];
			end
			// flat window: only one sample goes
			if (hi == lo) begin
				total -= hi;
				n = fill - 1;
			end else begin
				total -= hi + lo;
				n = fill - 2;
			end
			mean = total / n;  // truncates toward zero
			dec = (mean > int'(thr_model));
			if (dec != unlocked_now) begin
				unlocked_now = dec;
				d.unlock = dec;
				d.average = mean[SAMPLE_W-1:0];
				pending_decisions.push_back(d);
			end
		end
	endtask

	// entered and left just after a falling edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = idle_en ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_rssi <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_sample(s);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENABLE)
			en_model = val[0];
		else
			thr_model = val;
		@(negedge clk);
	endtask

	// stop sending, wait for every queued word, then let a trailing no-result word finish
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// fewer than three samples give no decision; three equal ones drop only one
	task automatic test_short_window();
		write_reg(CFG_ENABLE, 8'h01);
		send_sample(-8'sd40);
		send_sample(-8'sd40);
		send_sample(-8'sd40);
		drain();
	endtask

	// field extremes, ties for max and min, window fill and wrap
	task automatic test_extremes();
		send_sample(8'sd127);
		send_sample(8'sd127);
		send_sample(-8'sd128);
		send_sample(-8'sd128);
		send_sample(8'sd127);
		drain();
	endtask

	// -9/4 must give -2 (toward zero), which is above -3
	task automatic test_truncation();
		write_reg(CFG_THRESHOLD, -8'sd3);
		send_sample(8'sd0);
		send_sample(-8'sd3);
		send_sample(-8'sd2);
		send_sample(-8'sd2);
		send_sample(-8'sd2);
		send_sample(-8'sd3);
		drain();
	endtask

	// mean can never exceed 127; mean of -128 is not above -128
	task automatic test_threshold_limits();
		write_reg(CFG_THRESHOLD, 8'sd127);
		send_sample(8'sd127);
		send_sample(8'sd127);
		drain();
		write_reg(CFG_THRESHOLD, -8'sd128);
		send_sample(-8'sd128);
		send_sample(-8'sd128);
		send_sample(8'sd5);
		drain();
	endtask

	// disabled: samples still enter the window, no decision
	task automatic test_disabled();
		write_reg(CFG_ENABLE, 8'hFE);
		send_sample(-8'sd1);
		send_sample(8'sd0);
		send_sample(8'sd90);
		drain();
		write_reg(CFG_ENABLE, 8'h01);
		write_reg(CFG_THRESHOLD, THRESHOLD_RESET);
		send_sample(-8'sd100);
		drain();
	endtask

	// bursts on either side of the threshold so decisions keep flipping
	task automatic test_random_bursts(input int n_items);
		int                         sent;
		int                         level;
		bit                         above;
		logic signed [SAMPLE_W-1:0] thr;
		sent = 0;
		while (sent < n_items) begin
			drain();
			idle_en = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: thr = -8'sd128;
				1: thr = 8'sd127;
				default: thr = 8'($urandom_range(0, 255));
			endcase
			write_reg(CFG_THRESHOLD, thr);
			write_reg(CFG_ENABLE, {7'($urandom_range(0, 127)),
				1'($urandom_range(0, 5) != 0)});
			above = $urandom_range(0, 1);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					above = !above;
				if ($urandom_range(0, 7) == 0)
					level = $signed(8'($urandom_range(0, 255)));
				else if (above)
					level = int'(thr) + $urandom_range(1, 24);
				else
					level = int'(thr) - $urandom_range(0, 24);
				if (level > 127)
					level = 127;
				if (level < -128)
					level = -128;
				send_sample(level[SAMPLE_W-1:0]);
				sent++;
			end
		end
		drain();
	endtask

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_decisions.size() == 0) begin
				report_error("result word with no decision pending", unlock, -1);
			end else begin
				want = pending_decisions.pop_front();
				if (unlock !== want.unlock)
					report_error("unlock", unlock, want.unlock);
				if (average_rssi !== want.average)
					report_error("average_rssi", average_rssi, want.average);
			end
			ready_hold = idle_en ? $urandom_range(0, 5) : 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_rssi = '0;
		out_ready = 1'b0;
		ready_hold = 0;
		quiet_cycles = 0;
		err_count = 0;
		idle_en = 1'b1;
		fill = 0;
		slot = 0;
		unlocked_now = 1'b0;
		en_model = 1'b0;
		thr_model = THRESHOLD_RESET;
		foreach (win[i])
			win[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_window();
		test_extremes();
		test_truncation();
		test_threshold_limits();
		test_disabled();
		test_random_bursts(RANDOM_ITEMS);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
